// ----- hdl/lcdt_pkg.sv -----
// Shared codes, widths and result type for the LCD mode and line timing block.
package lcdt_pkg;

	localparam int PHASE_W = 10;
	localparam logic [PHASE_W-1:0] PHASE_MAX = '1;

	localparam logic [1:0] KIND_TICK  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam logic [1:0] MODE_HBLANK = 2'd0;
	localparam logic [1:0] MODE_VBLANK = 2'd1;
	localparam logic [1:0] MODE_OAM    = 2'd2;
	localparam logic [1:0] MODE_XFER   = 2'd3;

	localparam logic [3:0] REG_CONTROL = 4'd0;
	localparam logic [3:0] REG_STATUS  = 4'd1;
	localparam logic [3:0] REG_SCROLLY = 4'd2;
	localparam logic [3:0] REG_SCROLLX = 4'd3;
	localparam logic [3:0] REG_LINE    = 4'd4;
	localparam logic [3:0] REG_COMPARE = 4'd5;
	localparam logic [3:0] REG_BGPAL   = 4'd6;
	localparam logic [3:0] REG_OBPAL0  = 4'd7;
	localparam logic [3:0] REG_OBPAL1  = 4'd8;
	localparam logic [3:0] REG_WINY    = 4'd9;
	localparam logic [3:0] REG_WINX    = 4'd10;

	localparam logic [7:0] LAST_VISIBLE = 8'd143;
	localparam logic [7:0] LAST_LINE    = 8'd153;
	localparam logic [7:0] LINE_LIMIT   = 8'd154;

	// Bit positions: control display enable, and the status enables as stored (bits 6..3).
	localparam int CTL_DISPLAY = 7;
	localparam int EN_COINCIDE = 3;
	localparam int EN_OAM      = 2;
	localparam int EN_VBLANK   = 1;
	localparam int EN_HBLANK   = 0;

	localparam logic [1:0] SW_SCROLLY = 2'd0;
	localparam logic [1:0] SW_SCROLLX = 2'd1;
	localparam logic [1:0] SW_WINY    = 2'd2;
	localparam logic [1:0] SW_WINX    = 2'd3;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] line_now;
		logic [1:0] mode_now;
		logic       vblank_irq;
		logic       stat_irq;
	} result_t;

endpackage

// ----- hdl/lcd_mode_and_line_timing.sv -----
// LCD mode sequencing, line counter, line compare and register file.
//
// Usage: every input transfer carries one item: a timing tick (kind 0), a
// register write (kind 1) or a register read (kind 2). Each item yields exactly
// one result transfer with the read byte (zero unless a read), the line and
// mode after the item, and single-item interrupt request pulses.
// The state registers update at the input transfer and the result is registered
// in the output register, or in the skid register while the receiver stalls.
// Throughput is one item per cycle while the skid register is empty; the figure is set by
// the single pass of next-state logic between the state registers and the output register.
// When the receiver stalls, one further item is taken into a skid register, then input
// ready drops until the skid entry moves into the output register.
// Reset puts the state registers to zero: h-blank, line 0, phase count 0, display off,
// and clears the output valid flags. Ticks advance the timing with display off too.
module lcd_mode_and_line_timing #(
	parameter int OAM_LEN         = 80,
	parameter int TRANSFER_LEN    = 172,
	parameter int HBLANK_LEN      = 204,
	parameter int VBLANK_LINE_LEN = 456,
	parameter int TICK_STEP       = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] kind,
	input  logic [3:0] reg_index,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic [7:0] line_now,
	output logic [1:0] mode_now,
	output logic       vblank_irq,
	output logic       stat_irq
);

	localparam int PW = lcdt_pkg::PHASE_W;
	localparam logic [PW-1:0] OAM_L    = PW'(OAM_LEN);
	localparam logic [PW-1:0] XFER_L   = PW'(TRANSFER_LEN);
	localparam logic [PW-1:0] HBLANK_L = PW'(HBLANK_LEN);
	localparam logic [PW-1:0] VBLANK_L = PW'(VBLANK_LINE_LEN);
	localparam logic [PW:0]   STEP     = (PW+1)'(TICK_STEP);

	logic [1:0]    mode_q;
	logic [PW-1:0] phase_q;
	logic [7:0]    line_q;
	logic [7:0]    compare_q;
	logic [7:0]    control_q;
	logic [3:0]    enables_q;
	logic          coincide_q;
	logic [7:0]    sw_q [4];
	logic [7:0]    bgpal_q;
	logic [5:0]    obpal_q [2];

	logic [1:0]    mode_d;
	logic [PW-1:0] phase_d;
	logic [7:0]    line_d;
	logic [7:0]    compare_d;
	logic          coincide_d;
	logic          do_cmp;
	logic          cmp_eq;
	logic [PW-1:0] limit;
	logic [PW:0]   phase_sum;
	logic [7:0]    line_inc;
	lcdt_pkg::result_t res;

	lcdt_pkg::result_t out_q, skid_q;
	logic              out_valid_q, skid_valid_q;
	logic              accept;

	assign in_ready = !skid_valid_q;
	assign accept   = in_valid && in_ready;

	assign phase_sum = {1'b0, phase_q} + STEP;
	assign line_inc  = line_q + 8'd1;

	always_comb begin
		unique case (mode_q)
			lcdt_pkg::MODE_OAM:    limit = OAM_L;
			lcdt_pkg::MODE_XFER:   limit = XFER_L;
			lcdt_pkg::MODE_HBLANK: limit = HBLANK_L;
			default:               limit = VBLANK_L;
		endcase
	end

	always_comb begin
		mode_d         = mode_q;
		phase_d        = phase_q;
		line_d         = line_q;
		compare_d      = compare_q;
		do_cmp         = 1'b0;
		res            = '0;
		case (kind)
			lcdt_pkg::KIND_TICK: begin
				if (phase_q < limit) begin
					phase_d = phase_sum[PW] ? lcdt_pkg::PHASE_MAX : phase_sum[PW-1:0];
				end else begin
					phase_d = '0;
					unique case (mode_q)
						lcdt_pkg::MODE_OAM: begin
							mode_d = lcdt_pkg::MODE_XFER;
						end
						lcdt_pkg::MODE_XFER: begin
							mode_d = lcdt_pkg::MODE_HBLANK;
							res.stat_irq = enables_q[lcdt_pkg::EN_HBLANK];
						end
						lcdt_pkg::MODE_HBLANK: begin
							line_d = line_inc;
							do_cmp = (line_inc < lcdt_pkg::LINE_LIMIT);
							if (line_q == lcdt_pkg::LAST_VISIBLE) begin
								mode_d = lcdt_pkg::MODE_VBLANK;
								res.vblank_irq = control_q[lcdt_pkg::CTL_DISPLAY];
								res.stat_irq = enables_q[lcdt_pkg::EN_VBLANK];
							end else begin
								mode_d = lcdt_pkg::MODE_OAM;
								res.stat_irq = enables_q[lcdt_pkg::EN_OAM];
							end
						end
						default: begin
							do_cmp = 1'b1;
							if (line_q == lcdt_pkg::LAST_LINE) begin
								mode_d = lcdt_pkg::MODE_OAM;
								line_d = '0;
							end else begin
								line_d = line_inc;
								do_cmp = (line_inc < lcdt_pkg::LINE_LIMIT);
							end
						end
					endcase
				end
			end
			lcdt_pkg::KIND_WRITE: begin
				case (reg_index)
					lcdt_pkg::REG_CONTROL: begin
						// Turning the display off restarts the frame timing.
						if (control_q[lcdt_pkg::CTL_DISPLAY]
								&& !write_data[lcdt_pkg::CTL_DISPLAY]) begin
							phase_d = '0;
							mode_d  = lcdt_pkg::MODE_HBLANK;
							line_d  = '0;
							do_cmp  = 1'b1;
						end
					end
					lcdt_pkg::REG_LINE: line_d = write_data;
					lcdt_pkg::REG_COMPARE: begin
						compare_d = write_data;
						do_cmp    = 1'b1;
					end
					default: ;
				endcase
			end
			lcdt_pkg::KIND_READ: begin
				case (reg_index)
					lcdt_pkg::REG_CONTROL: res.read_data = control_q;
					lcdt_pkg::REG_STATUS:  res.read_data = {1'b0, enables_q, coincide_q, mode_q};
					lcdt_pkg::REG_SCROLLY: res.read_data = sw_q[lcdt_pkg::SW_SCROLLY];
					lcdt_pkg::REG_SCROLLX: res.read_data = sw_q[lcdt_pkg::SW_SCROLLX];
					lcdt_pkg::REG_LINE:    res.read_data = line_q;
					lcdt_pkg::REG_COMPARE: res.read_data = compare_q;
					lcdt_pkg::REG_BGPAL:   res.read_data = bgpal_q;
					lcdt_pkg::REG_OBPAL0:  res.read_data = {obpal_q[0], 2'b00};
					lcdt_pkg::REG_OBPAL1:  res.read_data = {obpal_q[1], 2'b00};
					lcdt_pkg::REG_WINY:    res.read_data = sw_q[lcdt_pkg::SW_WINY];
					lcdt_pkg::REG_WINX:    res.read_data = sw_q[lcdt_pkg::SW_WINX];
					default:               res.read_data = '0;
				endcase
			end
			default: ;
		endcase

		// The line compare runs after whatever moved the line or the compare value.
		cmp_eq     = (line_d == compare_d);
		coincide_d = coincide_q;
		if (do_cmp) begin
			coincide_d = cmp_eq;
			if (cmp_eq && enables_q[lcdt_pkg::EN_COINCIDE]) begin
				res.stat_irq = 1'b1;
			end
		end
		res.line_now = line_d;
		res.mode_now = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= lcdt_pkg::MODE_HBLANK;
			phase_q    <= '0;
			line_q     <= '0;
			compare_q  <= '0;
			control_q  <= '0;
			enables_q  <= '0;
			coincide_q <= 1'b0;
			sw_q[0]    <= '0;
			sw_q[1]    <= '0;
			sw_q[2]    <= '0;
			sw_q[3]    <= '0;
			bgpal_q    <= '0;
			obpal_q[0] <= '0;
			obpal_q[1] <= '0;
		end else if (accept) begin
			mode_q     <= mode_d;
			phase_q    <= phase_d;
			line_q     <= line_d;
			compare_q  <= compare_d;
			coincide_q <= coincide_d;
			if (kind == lcdt_pkg::KIND_WRITE) begin
				case (reg_index)
					lcdt_pkg::REG_CONTROL: control_q <= write_data;
					lcdt_pkg::REG_STATUS:  enables_q <= write_data[6:3];
					lcdt_pkg::REG_SCROLLY: sw_q[lcdt_pkg::SW_SCROLLY] <= write_data;
					lcdt_pkg::REG_SCROLLX: sw_q[lcdt_pkg::SW_SCROLLX] <= write_data;
					lcdt_pkg::REG_BGPAL:   bgpal_q <= write_data;
					lcdt_pkg::REG_OBPAL0:  obpal_q[0] <= write_data[7:2];
					lcdt_pkg::REG_OBPAL1:  obpal_q[1] <= write_data[7:2];
					lcdt_pkg::REG_WINY:    sw_q[lcdt_pkg::SW_WINY] <= write_data;
					lcdt_pkg::REG_WINX:    sw_q[lcdt_pkg::SW_WINX] <= write_data;
					default: ;
				endcase
			end
		end
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res;
			end
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = out_q.read_data;
	assign line_now   = out_q.line_now;
	assign mode_now   = out_q.mode_now;
	assign vblank_irq = out_q.vblank_irq;
	assign stat_irq   = out_q.stat_irq;

endmodule

// ----- verif/lcd_timing_checker.sv -----
// Checker for the LCD timing block: tracks the input transfers, predicts each result and compares.
module lcd_timing_checker #(
	parameter int OAM_LEN         = 80,
	parameter int TRANSFER_LEN    = 172,
	parameter int HBLANK_LEN      = 204,
	parameter int VBLANK_LINE_LEN = 456,
	parameter int TICK_STEP       = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] kind,
	input  logic [3:0] reg_index,
	input  logic [7:0] write_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] read_data,
	input  logic [7:0] line_now,
	input  logic [1:0] mode_now,
	input  logic       vblank_irq,
	input  logic       stat_irq,
	output int         errors,
	output int         pending,
	output int         checked,
	output int         vblank_count,
	output int         stat_count
);

	localparam int PW = lcdt_pkg::PHASE_W;
	localparam int EXP_DEPTH = 8;

	// Predicted copy of the timing state and register file.
	logic [1:0]         lcd_mode;
	logic [PW-1:0]      lcd_phase;
	logic [7:0]         lcd_line;
	logic [7:0]         lcd_cmp;
	logic [7:0]         lcd_ctl;
	logic [3:0]         lcd_en;
	logic               lcd_coinc;
	logic [7:0]         lcd_sw [4];
	logic [7:0]         lcd_bgp;
	logic [5:0]         lcd_obp [2];
	logic               irq_v;
	logic               irq_s;

	// Expected results in transfer order, kept in a small ring.
	lcdt_pkg::result_t exp_store [EXP_DEPTH];
	int exp_rd;
	int exp_wr;
	int exp_count;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at result %0d: %s got %0d, expected %0d", checked, what, got, want);
		errors++;
	endtask

	task automatic check_coincidence();
		if (lcd_line == lcd_cmp) begin
			lcd_coinc = 1'b1;
			if (lcd_en[lcdt_pkg::EN_COINCIDE])
				irq_s = 1'b1;
		end else begin
			lcd_coinc = 1'b0;
		end
	endtask

	// Lines that advance to 154 or beyond leave the coincidence flag alone.
	task automatic advance_line();
		lcd_line = lcd_line + 8'd1;
		if (lcd_line < lcdt_pkg::LINE_LIMIT)
			check_coincidence();
	endtask

	task automatic timing_tick();
		int limit;
		int grown;
		case (lcd_mode)
			lcdt_pkg::MODE_OAM:    limit = OAM_LEN;
			lcdt_pkg::MODE_XFER:   limit = TRANSFER_LEN;
			lcdt_pkg::MODE_HBLANK: limit = HBLANK_LEN;
			default:               limit = VBLANK_LINE_LEN;
		endcase
		if (int'(lcd_phase) < limit) begin
			grown = int'(lcd_phase) + TICK_STEP;
			lcd_phase = (grown > int'(lcdt_pkg::PHASE_MAX)) ? lcdt_pkg::PHASE_MAX : PW'(grown);
		end else begin
			lcd_phase = '0;
			case (lcd_mode)
				lcdt_pkg::MODE_OAM: lcd_mode = lcdt_pkg::MODE_XFER;
				lcdt_pkg::MODE_XFER: begin
					lcd_mode = lcdt_pkg::MODE_HBLANK;
					if (lcd_en[lcdt_pkg::EN_HBLANK])
						irq_s = 1'b1;
				end
				lcdt_pkg::MODE_HBLANK: begin
					if (lcd_line == lcdt_pkg::LAST_VISIBLE) begin
						lcd_mode = lcdt_pkg::MODE_VBLANK;
						if (lcd_ctl[lcdt_pkg::CTL_DISPLAY])
							irq_v = 1'b1;
						if (lcd_en[lcdt_pkg::EN_VBLANK])
							irq_s = 1'b1;
						advance_line();
					end else begin
						advance_line();
						lcd_mode = lcdt_pkg::MODE_OAM;
						if (lcd_en[lcdt_pkg::EN_OAM])
							irq_s = 1'b1;
					end
				end
				default: begin
					if (lcd_line == lcdt_pkg::LAST_LINE) begin
						lcd_mode = lcdt_pkg::MODE_OAM;
						lcd_line = 8'd0;
						check_coincidence();
					end else begin
						advance_line();
					end
				end
			endcase
		end
	endtask

	task automatic register_write(input logic [3:0] idx, input logic [7:0] d);
		case (idx)
			lcdt_pkg::REG_CONTROL: begin
				// Turning the display off restarts the frame at line 0 in h-blank.
				if (lcd_ctl[lcdt_pkg::CTL_DISPLAY] && !d[lcdt_pkg::CTL_DISPLAY]) begin
					lcd_phase = '0;
					lcd_mode = lcdt_pkg::MODE_HBLANK;
					lcd_line = 8'd0;
					check_coincidence();
				end
				lcd_ctl = d;
			end
			lcdt_pkg::REG_STATUS:  lcd_en = d[6:3];
			lcdt_pkg::REG_SCROLLY: lcd_sw[lcdt_pkg::SW_SCROLLY] = d;
			lcdt_pkg::REG_SCROLLX: lcd_sw[lcdt_pkg::SW_SCROLLX] = d;
			lcdt_pkg::REG_LINE:    lcd_line = d;
			lcdt_pkg::REG_COMPARE: begin
				lcd_cmp = d;
				check_coincidence();
			end
			lcdt_pkg::REG_BGPAL:   lcd_bgp = d;
			lcdt_pkg::REG_OBPAL0:  lcd_obp[0] = d[7:2];
			lcdt_pkg::REG_OBPAL1:  lcd_obp[1] = d[7:2];
			lcdt_pkg::REG_WINY:    lcd_sw[lcdt_pkg::SW_WINY] = d;
			lcdt_pkg::REG_WINX:    lcd_sw[lcdt_pkg::SW_WINX] = d;
			default: ;
		endcase
	endtask

	function automatic logic [7:0] register_read(input logic [3:0] idx);
		case (idx)
			lcdt_pkg::REG_CONTROL: return lcd_ctl;
			lcdt_pkg::REG_STATUS:  return {1'b0, lcd_en, lcd_coinc, lcd_mode};
			lcdt_pkg::REG_SCROLLY: return lcd_sw[lcdt_pkg::SW_SCROLLY];
			lcdt_pkg::REG_SCROLLX: return lcd_sw[lcdt_pkg::SW_SCROLLX];
			lcdt_pkg::REG_LINE:    return lcd_line;
			lcdt_pkg::REG_COMPARE: return lcd_cmp;
			lcdt_pkg::REG_BGPAL:   return lcd_bgp;
			lcdt_pkg::REG_OBPAL0:  return {lcd_obp[0], 2'b00};
			lcdt_pkg::REG_OBPAL1:  return {lcd_obp[1], 2'b00};
			lcdt_pkg::REG_WINY:    return lcd_sw[lcdt_pkg::SW_WINY];
			lcdt_pkg::REG_WINX:    return lcd_sw[lcdt_pkg::SW_WINX];
			default:               return 8'd0;
		endcase
	endfunction

	task automatic predict_lcd(input logic [1:0] k, input logic [3:0] idx, input logic [7:0] d,
			output lcdt_pkg::result_t res);
		res = '0;
		irq_v = 1'b0;
		irq_s = 1'b0;
		case (k)
			lcdt_pkg::KIND_TICK:  timing_tick();
			lcdt_pkg::KIND_WRITE: register_write(idx, d);
			lcdt_pkg::KIND_READ:  res.read_data = register_read(idx);
			default: ;
		endcase
		res.line_now = lcd_line;
		res.mode_now = lcd_mode;
		res.vblank_irq = irq_v;
		res.stat_irq = irq_s;
	endtask

	always @(posedge clk or negedge arst_n) begin
		lcdt_pkg::result_t want;
		if (!arst_n) begin
			lcd_mode = lcdt_pkg::MODE_HBLANK;
			lcd_phase = '0;
			lcd_line = '0;
			lcd_cmp = '0;
			lcd_ctl = '0;
			lcd_en = '0;
			lcd_coinc = 1'b0;
			foreach (lcd_sw[i])
				lcd_sw[i] = '0;
			lcd_bgp = '0;
			lcd_obp[0] = '0;
			lcd_obp[1] = '0;
			exp_rd = 0;
			exp_wr = 0;
			exp_count = 0;
			pending = 0;
		end else begin
			// The result side is handled first: a result always belongs to an older item.
			if (out_valid && out_ready) begin
				if (exp_count == 0) begin
					report_mismatch("result with nothing expected, line", line_now, -1);
				end else begin
					want = exp_store[exp_rd];
					exp_rd = (exp_rd + 1) % EXP_DEPTH;
					exp_count--;
					if (read_data !== want.read_data)
						report_mismatch("read_data", read_data, want.read_data);
					if (line_now !== want.line_now)
						report_mismatch("line_now", line_now, want.line_now);
					if (mode_now !== want.mode_now)
						report_mismatch("mode_now", mode_now, want.mode_now);
					if (vblank_irq !== want.vblank_irq)
						report_mismatch("vblank_irq", vblank_irq, want.vblank_irq);
					if (stat_irq !== want.stat_irq)
						report_mismatch("stat_irq", stat_irq, want.stat_irq);
				end
				checked++;
				if (vblank_irq === 1'b1)
					vblank_count++;
				if (stat_irq === 1'b1)
					stat_count++;
			end
			if (in_valid && in_ready) begin
				predict_lcd(kind, reg_index, write_data, want);
				if (exp_count == EXP_DEPTH) begin
					report_mismatch("items in flight", exp_count + 1, EXP_DEPTH);
				end else begin
					exp_store[exp_wr] = want;
					exp_wr = (exp_wr + 1) % EXP_DEPTH;
					exp_count++;
				end
			end
			pending = exp_count;
		end
	end

endmodule

// ----- verif/tb_lcd_mode_and_line_timing.sv -----
// Testbench top for the LCD timing block: stimulus, receiver stalls and the verdict.
module tb_lcd_mode_and_line_timing;

	localparam int OAM_LEN         = 80;
	localparam int TRANSFER_LEN    = 172;
	localparam int HBLANK_LEN      = 204;
	localparam int VBLANK_LINE_LEN = 456;
	localparam int TICK_STEP       = 4;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam logic [3:0] REG_UNKNOWN = 4'd15;
	localparam int PHASE_ITEMS = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] kind = lcdt_pkg::KIND_TICK;
	logic [3:0] reg_index = lcdt_pkg::REG_CONTROL;
	logic [7:0] write_data = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] read_data;
	logic [7:0] line_now;
	logic [1:0] mode_now;
	logic       vblank_irq;
	logic       stat_irq;

	int errors;
	int pending;
	int checked;
	int vblank_count;
	int stat_count;

	int gap_pct = 0;
	int stall_pct = 0;
	bit pressure_on = 1'b0;
	int items_sent = 0;
	int cycle_count = 0;
	logic [1:0] seen_mode = lcdt_pkg::MODE_HBLANK;
	int mode_changes = 0;
	int mode_changes_used = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	lcd_mode_and_line_timing #(
		.OAM_LEN(OAM_LEN),
		.TRANSFER_LEN(TRANSFER_LEN),
		.HBLANK_LEN(HBLANK_LEN),
		.VBLANK_LINE_LEN(VBLANK_LINE_LEN),
		.TICK_STEP(TICK_STEP)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.reg_index(reg_index),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.line_now(line_now),
		.mode_now(mode_now),
		.vblank_irq(vblank_irq),
		.stat_irq(stat_irq)
	);

	lcd_timing_checker #(
		.OAM_LEN(OAM_LEN),
		.TRANSFER_LEN(TRANSFER_LEN),
		.HBLANK_LEN(HBLANK_LEN),
		.VBLANK_LINE_LEN(VBLANK_LINE_LEN),
		.TICK_STEP(TICK_STEP)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.reg_index(reg_index),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_data(read_data),
		.line_now(line_now),
		.mode_now(mode_now),
		.vblank_irq(vblank_irq),
		.stat_irq(stat_irq),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.vblank_count(vblank_count),
		.stat_count(stat_count)
	);

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Follow the mode seen on the result side so the stimulus can steer the line counter.
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (mode_now != seen_mode)
				mode_changes <= mode_changes + 1;
			seen_mode <= mode_now;
		end
	end

	// Receiver: random stalls, and during the pressure phase long hold-offs that fill the block.
	initial begin : receiver
		int hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (pressure_on && hold_left == 0 && (!held || $urandom_range(0, 199) == 0)) begin
				hold_left = $urandom_range(40, 90);
				held = 1'b1;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	task automatic send_item(input logic [1:0] k, input logic [3:0] idx, input logic [7:0] d);
		int gap;
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		reg_index <= idx;
		write_data <= d;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	function automatic logic [7:0] pick_line();
		case ($urandom_range(0, 4))
			0: return 8'($urandom_range(141, 155));
			1: return 8'($urandom_range(250, 255));
			2: return 8'($urandom_range(0, 3));
			3: return lcdt_pkg::LAST_VISIBLE;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_compare();
		case ($urandom_range(0, 5))
			0: return 8'($urandom_range(142, 146));
			1: return 8'($urandom_range(152, 154));
			2: return 8'($urandom_range(0, 2));
			3: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// Right after a mode change, often move the line to where the next boundary matters:
	// the last visible line in h-blank, the last line or the wrap point in v-blank.
	function automatic logic [7:0] steer_line(input logic [1:0] m);
		if (m == lcdt_pkg::MODE_HBLANK) begin
			case ($urandom_range(0, 4))
				0, 1: return lcdt_pkg::LAST_VISIBLE;
				2: return 8'd255;
				default: return pick_line();
			endcase
		end else if (m == lcdt_pkg::MODE_VBLANK) begin
			case ($urandom_range(0, 4))
				0, 1: return lcdt_pkg::LAST_LINE;
				2: return 8'd255;
				3: return 8'($urandom_range(150, 153));
				default: return pick_line();
			endcase
		end
		return pick_line();
	endfunction

	task automatic pick_item(output logic [1:0] k, output logic [3:0] idx, output logic [7:0] d);
		int r;
		bit fresh;
		r = $urandom_range(0, 99);
		fresh = (mode_changes != mode_changes_used);
		mode_changes_used = mode_changes;
		k = lcdt_pkg::KIND_TICK;
		idx = 4'($urandom_range(0, 15));
		d = 8'($urandom);
		if (fresh && r < 60) begin
			k = lcdt_pkg::KIND_WRITE;
			idx = lcdt_pkg::REG_LINE;
			d = steer_line(seen_mode);
		end else if (r < 78) begin
			k = lcdt_pkg::KIND_TICK;
		end else if (r < 83) begin
			k = lcdt_pkg::KIND_WRITE;
			idx = lcdt_pkg::REG_LINE;
			d = pick_line();
		end else if (r < 87) begin
			k = lcdt_pkg::KIND_WRITE;
			idx = lcdt_pkg::REG_COMPARE;
			d = pick_compare();
		end else if (r < 90) begin
			k = lcdt_pkg::KIND_WRITE;
			idx = lcdt_pkg::REG_CONTROL;
			d[lcdt_pkg::CTL_DISPLAY] = ($urandom_range(0, 99) < 80);
		end else if (r < 92) begin
			k = lcdt_pkg::KIND_WRITE;
			idx = lcdt_pkg::REG_STATUS;
		end else if (r < 94) begin
			k = lcdt_pkg::KIND_WRITE;
		end else if (r < 99) begin
			k = lcdt_pkg::KIND_READ;
			if ($urandom_range(0, 7) != 0)
				idx = 4'($urandom_range(0, 10));
		end else begin
			k = KIND_NONE;
		end
	endtask

	initial begin : stimulus
		int gap_list [6];
		int stall_list [6];
		logic [1:0] k;
		logic [3:0] idx;
		logic [7:0] d;
		gap_list = '{0, 55, 0, 34, 0, 34};
		stall_list = '{0, 0, 55, 34, 10, 34};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: unknown kind and index, register extremes, line 255, display off.
		send_item(KIND_NONE, REG_UNKNOWN, 8'hFF);
		send_item(lcdt_pkg::KIND_READ, REG_UNKNOWN, 8'h00);
		send_item(lcdt_pkg::KIND_WRITE, REG_UNKNOWN, 8'hFF);
		send_item(lcdt_pkg::KIND_WRITE, lcdt_pkg::REG_CONTROL, 8'hFF);
		send_item(lcdt_pkg::KIND_WRITE, lcdt_pkg::REG_STATUS, 8'hFF);
		send_item(lcdt_pkg::KIND_WRITE, lcdt_pkg::REG_COMPARE, 8'h00);
		send_item(lcdt_pkg::KIND_READ, lcdt_pkg::REG_STATUS, 8'h00);
		send_item(lcdt_pkg::KIND_WRITE, lcdt_pkg::REG_OBPAL0, 8'hFF);
		send_item(lcdt_pkg::KIND_READ, lcdt_pkg::REG_OBPAL0, 8'h00);
		send_item(lcdt_pkg::KIND_WRITE, lcdt_pkg::REG_OBPAL1, 8'h03);
		send_item(lcdt_pkg::KIND_READ, lcdt_pkg::REG_OBPAL1, 8'h00);
		send_item(lcdt_pkg::KIND_WRITE, lcdt_pkg::REG_WINX, 8'hFF);
		send_item(lcdt_pkg::KIND_READ, lcdt_pkg::REG_WINX, 8'h00);
		send_item(lcdt_pkg::KIND_WRITE, lcdt_pkg::REG_LINE, 8'hFF);
		send_item(lcdt_pkg::KIND_TICK, lcdt_pkg::REG_CONTROL, 8'h00);
		send_item(lcdt_pkg::KIND_READ, lcdt_pkg::REG_LINE, 8'h00);
		send_item(lcdt_pkg::KIND_WRITE, lcdt_pkg::REG_CONTROL, 8'h00);
		send_item(lcdt_pkg::KIND_READ, lcdt_pkg::REG_CONTROL, 8'h00);
		send_item(lcdt_pkg::KIND_READ, lcdt_pkg::REG_LINE, 8'h00);
		send_item(lcdt_pkg::KIND_TICK, REG_UNKNOWN, 8'hFF);

		for (int p = 0; p < 6; p++) begin
			gap_pct = gap_list[p];
			stall_pct = stall_list[p];
			pressure_on = (p == 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick_item(k, idx, d);
				send_item(k, idx, d);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		pressure_on = 1'b0;
		stall_pct = 0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d items and %0d checked results over %0d mode changes,",
			items_sent, checked, mode_changes);
		$display("with %0d v-blank and %0d STAT requests seen, in %0d cycles.",
			vblank_count, stat_count, cycle_count);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
